// ===== sv/sle_pkg.sv =====
package sle_pkg;

    localparam int LINE_SLOTS = 64;
    localparam int LEN_W      = $clog2(LINE_SLOTS);
    localparam int CAP_W      = 7;
    localparam int BYTE_W     = 8;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;

    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_TERM
    } state_t;

endpackage

// ===== sv/serial_line_editor_top.sv =====
// Serial line editor.
// Input channel: in_valid / in_ready carry one received byte (rx_byte) per word.
// Output channel: out_valid / out_ready carry one line character (line_char)
// per word; line_end marks the zero terminator word that closes a line.
// Configuration: cfg_write_en writes cfg_write_data into the line capacity
// register; write it only while the block is idle.
// Carriage returns, backspaces, DEL and ordinary bytes are accepted while the
// block is idle and produce no output words. A newline starts a drain of the
// kept characters from the line memory, at most one fewer than the capacity:
// each character passes through the synchronous memory read (ST_READ) and
// then the load of the output register (ST_LOAD), and the terminator follows
// (ST_TERM). The input is held off from the newline until the terminator is
// loaded; on a line with no characters only the terminator is sent.
// When the receiver stalls, the output register holds its word and the
// drain waits; nothing is lost. Reset empties the line, sets the capacity to
// 64 and leaves the memory contents undefined; no clearing pass is needed.
module serial_line_editor_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sle_pkg::BYTE_W-1:0]   rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sle_pkg::BYTE_W-1:0]   line_char,
    output logic                         line_end,
    input  logic                         cfg_write_en,
    input  logic [sle_pkg::CAP_W-1:0]    cfg_write_data
);

    localparam int LEN_W  = sle_pkg::LEN_W;
    localparam int CAP_W  = sle_pkg::CAP_W;
    localparam int BYTE_W = sle_pkg::BYTE_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(sle_pkg::LINE_SLOTS - 1);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    logic [BYTE_W-1:0] line_mem [sle_pkg::LINE_SLOTS];

    sle_pkg::state_t    state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [CAP_W-1:0]   cap_reg;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_char_reg, out_char_next;
    logic               out_end_reg, out_end_next;
    logic [BYTE_W-1:0]  rd_data_reg;

    logic               in_fire;
    logic               mem_we;
    logic               slot_free;
    logic [CAP_W-1:0]   cap_m1;
    logic [CAP_W-1:0]   len_wide;
    logic [LEN_W-1:0]   emit_cnt;

    assign in_ready  = (state_reg == sle_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign line_char = out_char_reg;
    assign line_end  = out_end_reg;

    assign cap_m1   = (cap_reg == '0) ? '0 : cap_reg - CAP_W'(1);
    assign len_wide = CAP_W'(len_reg);
    assign emit_cnt = (len_wide < cap_m1) ? len_reg : cap_m1[LEN_W-1:0];

    assign mem_we = in_fire && (rx_byte != sle_pkg::CH_CR) && (rx_byte != sle_pkg::CH_LF)
                    && (rx_byte != sle_pkg::CH_BS) && (rx_byte != sle_pkg::CH_DEL)
                    && (len_reg < LEN_MAX);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[len_reg] <= rx_byte;
        end
        rd_data_reg <= line_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sle_pkg::ST_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            cap_reg       <= sle_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_end_reg  <= out_end_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_end_next   = out_end_reg;
        case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (rx_byte == sle_pkg::CH_LF)
                    begin
                        idx_next   = '0;
                        cnt_next   = emit_cnt;
                        len_next   = '0;
                        state_next = (emit_cnt == '0) ? sle_pkg::ST_TERM : sle_pkg::ST_READ;
                    end
                    else if ((rx_byte == sle_pkg::CH_BS) || (rx_byte == sle_pkg::CH_DEL))
                    begin
                        if (len_reg != '0)
                        begin
                            len_next = len_reg - LEN_ONE;
                        end
                    end
                    else if (mem_we)
                    begin
                        len_next = len_reg + LEN_ONE;
                    end
                end
            end
            sle_pkg::ST_READ:
            begin
                state_next = sle_pkg::ST_LOAD;
            end
            sle_pkg::ST_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data_reg;
                    out_end_next   = 1'b0;
                    idx_next       = idx_reg + LEN_ONE;
                    state_next     = (idx_reg == cnt_reg - LEN_ONE) ? sle_pkg::ST_TERM
                                                                    : sle_pkg::ST_READ;
                end
            end
            sle_pkg::ST_TERM:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_end_next   = 1'b1;
                    state_next     = sle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("line length beyond the last slot");

    a_newline_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (rx_byte == sle_pkg::CH_LF)) |=> !in_ready)
        else $error("input taken during a line drain");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sle_pkg::ST_LOAD) |-> (idx_reg < cnt_reg))
        else $error("drain index past the emitted length");

    a_drain_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sle_pkg::ST_IDLE) |-> (len_reg == '0))
        else $error("line not cleared while draining");

endmodule

// ===== tb/tb_serial_line_editor_top.sv =====
`timescale 1ns / 1ps

module tb_serial_line_editor_top;

    typedef struct packed {
        logic [sle_pkg::BYTE_W-1:0] chr;
        logic                       is_end;
    } line_word_t;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [sle_pkg::BYTE_W-1:0] rx_byte = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [sle_pkg::BYTE_W-1:0] line_char;
    logic                       line_end;
    logic                       cfg_write_en = 1'b0;
    logic [sle_pkg::CAP_W-1:0]  cfg_write_data = '0;

    logic [sle_pkg::BYTE_W-1:0] byte_q[$];
    line_word_t                 expected_words[$];

    logic [sle_pkg::BYTE_W-1:0] line_mem[sle_pkg::LINE_SLOTS];
    int                         line_len = 0;
    logic [sle_pkg::CAP_W-1:0]  line_cap = sle_pkg::CAP_RESET;

    int  bytes_in = 0;
    int  words_out = 0;
    int  fail_count = 0;
    int  settings_done = 1;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    bit  stall_request = 1'b0;
    bit  stall_seen = 1'b0;

    serial_line_editor_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_char      (line_char),
        .line_end       (line_end),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #2 clk = ~clk;

    task automatic edit_line(input logic [sle_pkg::BYTE_W-1:0] b);
        int cap;
        int n;
        if (b == sle_pkg::CH_LF)
        begin
            cap = (line_cap == 0) ? 1 : int'(line_cap);
            n = line_len;
            if (n >= cap)
                n = cap - 1;
            if (n > sle_pkg::LINE_SLOTS - 1)
                n = sle_pkg::LINE_SLOTS - 1;
            for (int i = 0; i < n; i++)
                expected_words.push_back(line_word_t'{chr: line_mem[i], is_end: 1'b0});
            expected_words.push_back(line_word_t'{chr: '0, is_end: 1'b1});
            line_len = 0;
        end
        else if (b == sle_pkg::CH_BS || b == sle_pkg::CH_DEL)
        begin
            if (line_len > 0)
                line_len--;
        end
        else if (b != sle_pkg::CH_CR && line_len < sle_pkg::LINE_SLOTS - 1)
        begin
            line_mem[line_len] = b;
            line_len++;
        end
    endtask

    task automatic queue_line(input int len);
        logic [sle_pkg::BYTE_W-1:0] b;
        for (int k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 9))
                0: b = sle_pkg::BYTE_W'($urandom_range(0, 255));
                1: b = $urandom_range(0, 1) ? sle_pkg::CH_BS : sle_pkg::CH_DEL;
                2: b = sle_pkg::CH_CR;
                default: b = sle_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E));
            endcase
            byte_q.push_back(b);
        end
        byte_q.push_back(sle_pkg::CH_LF);
    endtask

    // Overfills the line, then queues a backspace and two bytes so that the scoreboard shows it frees exactly one slot.
    task automatic queue_full_line();
        int len;
        len = $urandom_range(sle_pkg::LINE_SLOTS + 2, sle_pkg::LINE_SLOTS + 8);
        for (int k = 0; k < len; k++)
            byte_q.push_back(sle_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E)));
        byte_q.push_back(sle_pkg::CH_BS);
        byte_q.push_back(8'h5A);
        byte_q.push_back(8'h5B);
        byte_q.push_back(sle_pkg::CH_LF);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [sle_pkg::CAP_W-1:0] value);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        line_cap = value;
        settings_done++;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [sle_pkg::CAP_W-1:0] cap, input int items,
                             input bit with_full);
        wait_idle();
        write_capacity(cap);
        if (with_full)
            queue_full_line();
        while (byte_q.size() < items)
            queue_line($urandom_range(0, 12));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                edit_line(rx_byte);
                bytes_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() > 0)
                begin
                    rx_byte  <= byte_q.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        line_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                words_out++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: line_char %02h line_end %0b", line_char, line_end);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (line_char !== want.chr)
                    begin
                        $error("line_char mismatch: expected %02h, actual %02h",
                               want.chr, line_char);
                        fail_count++;
                    end
                    if (line_end !== want.is_end)
                    begin
                        $error("line_end mismatch: expected %0b, actual %0b",
                               want.is_end, line_end);
                        fail_count++;
                    end
                end
                if (stall_request && !line_end)
                begin
                    stall_request = 1'b0;
                    stall_seen    = 1'b1;
                    hold_left     = LONG_HOLD;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Edits on an empty line, field extremes, then a short edited line.
        byte_q.push_back(sle_pkg::CH_BS);
        byte_q.push_back(sle_pkg::CH_DEL);
        byte_q.push_back(sle_pkg::CH_LF);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h41);
        byte_q.push_back(sle_pkg::CH_CR);
        byte_q.push_back(sle_pkg::CH_BS);
        byte_q.push_back(8'h42);
        byte_q.push_back(8'h80);
        byte_q.push_back(sle_pkg::CH_DEL);
        byte_q.push_back(8'h7E);
        byte_q.push_back(8'h01);
        byte_q.push_back(8'h09);
        byte_q.push_back(8'h0B);
        byte_q.push_back(8'h0C);
        byte_q.push_back(8'h0E);
        byte_q.push_back(8'h55);
        byte_q.push_back(8'hAA);
        byte_q.push_back(sle_pkg::CH_LF);
        byte_q.push_back(sle_pkg::CH_CR);
        byte_q.push_back(sle_pkg::CH_LF);

        run_phase(7'd1, 30, 1'b0);
        run_phase(7'd0, 30, 1'b0);
        stall_request = 1'b1;
        run_phase(7'd127, 40, 1'b1);
        run_phase(sle_pkg::CAP_W'($urandom_range(2, 63)), 40, 1'b0);
        run_phase(7'd2, 30, 1'b0);
        wait_idle();
        idle_on = 1'b0;
        run_phase(7'd64, 40, 1'b1);
        wait_idle();

        $display("Run covered %0d bytes in and %0d line words out over %0d capacity settings.",
                 bytes_in, words_out, settings_done);
        $display("Long receiver hold with input backpressure exercised: %0b.", stall_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
